FILE: src/lru_key_value_cache_unit_defines.svh
// assertion macros for the lru key-value cache
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define LKVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lkvc assertion failed");

// condition implies consequence in the next cycle
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

FILE: src/lkvc_pkg.sv
// types and constants shared by the lru key-value cache modules
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int WORD_W  = 32;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int PADDR_W = 3;
    localparam int REG_W   = PADDR_W - 2;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(16);
    localparam logic [REG_W-1:0] REG_CAPACITY = REG_W'(0);

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [RANK_W-1:0] t_rank;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [ENTRIES-1:0] t_slot_vec;

    typedef struct packed {
        t_slot_vec match;
        logic      hit;
        t_rank     hit_rank;
        t_word     hit_data;
        t_slot_vec free_slot;
        t_slot_vec victim;
    } t_lookup;

endpackage

FILE: src/lru_key_value_cache_unit.sv
// the result strobe comes from the result register; one item per cycle sustained
// the lookup and age-rank update for an item complete combinationally between
// the item register and the result register, so busy never rises
// reset (synchronous, active low) empties the cache and sets the capacity to 16
// results cannot be held off by the receiver
module lru_key_value_cache_unit import lkvc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [WORD_W-1:0]  i_key,
    input  logic [WORD_W-1:0]  i_value,
    output logic               o_result_valid,
    output logic               o_hit,
    output logic [WORD_W-1:0]  o_read_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic             r_in_valid;
    logic             r_action;
    t_word            r_key;
    t_word            r_value;
    logic             r_out_valid;
    logic             r_hit;
    t_word            r_read_value;
    logic [CAP_W-1:0] r_capacity;

    logic             accept;
    logic             cfg_write;
    logic             n_hit;
    t_word            n_read_value;

    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1:2] == REG_CAPACITY);

    always_comb begin
        if (paddr[PADDR_W-1:2] == REG_CAPACITY) begin
            prdata = PDATA_W'(r_capacity);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_write) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
        if (accept) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_value  <= i_value;
        end
    end

    lkvc_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_action     (r_action),
        .i_key        (r_key),
        .i_value      (r_value),
        .i_capacity   (r_capacity),
        .o_hit        (n_hit),
        .o_read_value (n_read_value)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_hit        <= n_hit;
            r_read_value <= n_read_value;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_hit          = r_hit;
    assign o_read_value   = r_read_value;

endmodule

FILE: src/lkvc_lookup.sv
// parallel key compare, free slot pick and lru victim pick
module lkvc_lookup import lkvc_pkg::*; (
    input  t_word     i_key,
    input  t_word     i_entry_key  [ENTRIES],
    input  t_word     i_entry_data [ENTRIES],
    input  t_rank     i_entry_rank [ENTRIES],
    input  t_slot_vec i_entry_valid,
    input  t_count    i_count,
    output t_lookup   o_lookup
);

    t_slot_vec match;
    t_slot_vec victim;
    t_slot_vec invalid;
    t_rank     hit_rank;
    t_word     hit_data;
    t_count    oldest;

    assign oldest  = i_count - 1'b1;
    assign invalid = ~i_entry_valid;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = i_entry_valid[i] && (i_entry_key[i] == i_key);
            // ranks of valid entries form a permutation, so the oldest is unique
            victim[i] = i_entry_valid[i] && (t_count'(i_entry_rank[i]) == oldest);
        end
    end

    // at most one match, so an or of masked entries selects it
    always_comb begin
        hit_rank = '0;
        hit_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
                hit_rank = hit_rank | i_entry_rank[i];
                hit_data = hit_data | i_entry_data[i];
            end
        end
    end

    always_comb begin
        o_lookup.match     = match;
        o_lookup.hit       = |match;
        o_lookup.hit_rank  = hit_rank;
        o_lookup.hit_data  = hit_data;
        // lowest invalid slot
        o_lookup.free_slot = invalid & (~invalid + 1'b1);
        o_lookup.victim    = victim;
    end

endmodule

FILE: src/lkvc_store.sv
// entry storage and age-rank update for the lru key-value cache
`include "lru_key_value_cache_unit_defines.svh"

module lkvc_store import lkvc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  logic             i_action,
    input  t_word            i_key,
    input  t_word            i_value,
    input  logic [CAP_W-1:0] i_capacity,
    output logic             o_hit,
    output t_word            o_read_value
);

    t_word     r_key  [ENTRIES];
    t_word     r_data [ENTRIES];
    t_rank     r_rank [ENTRIES];
    t_slot_vec r_valid;
    t_count    r_count;

    t_lookup          lk;
    logic [CMP_W-1:0] cap_x;
    logic [CMP_W-1:0] eff_cap;
    logic             has_room;
    logic             do_touch;
    logic             ins;
    t_slot_vec        sel;
    t_count           old_rank;

    lkvc_lookup u_lookup (
        .i_key         (i_key),
        .i_entry_key   (r_key),
        .i_entry_data  (r_data),
        .i_entry_rank  (r_rank),
        .i_entry_valid (r_valid),
        .i_count       (r_count),
        .o_lookup      (lk)
    );

    always_comb begin
        cap_x = CMP_W'(i_capacity);
        if (cap_x == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_x > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_x;
        end
        has_room = CMP_W'(r_count) < eff_cap;
        do_touch = lk.hit | i_action;
        ins      = ~lk.hit & i_action;
        if (lk.hit) begin
            sel      = lk.match;
            old_rank = t_count'(lk.hit_rank);
        end else if (has_room) begin
            sel      = lk.free_slot;
            old_rank = r_count;
        end else begin
            sel      = lk.victim;
            old_rank = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_item_valid && do_touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (sel[i]) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (t_count'(r_rank[i]) < old_rank)) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
            if (ins) begin
                r_valid <= r_valid | sel;
                if (has_room) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item_valid && i_action) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (sel[i]) begin
                    r_data[i] <= i_value;
                    if (!lk.hit) begin
                        r_key[i] <= i_key;
                    end
                end
            end
        end
    end

    assign o_hit        = lk.hit;
    assign o_read_value = (lk.hit && !i_action) ? lk.hit_data : '0;

    `LKVC_ASSERT_IMP(a_count_matches_valid, i_clk, i_rst_n, 1'b1, $countones(r_valid) == r_count)
    `LKVC_ASSERT_IMP(a_single_match, i_clk, i_rst_n, i_item_valid, $onehot0(lk.match))
    `LKVC_ASSERT_IMP(a_hit_rank_in_use, i_clk, i_rst_n, i_item_valid && lk.hit, t_count'(lk.hit_rank) < r_count)
    `LKVC_ASSERT_NEXT(a_get_keeps_count, i_clk, i_rst_n, i_item_valid && !i_action, $stable(r_count))

endmodule
